[hw/rtl/tcs_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and saturation helpers for the triangle corner strain core
package tcs_pkg;

  localparam int CRD_W   = 32;
  localparam int EDGE_W  = 33;
  localparam int PROD_W  = 66;
  localparam int DET_W   = 67;
  localparam int F_W     = 34;
  localparam int FPROD_W = 68;
  localparam int CM_W    = 70;
  localparam int U_QW    = 32;

  localparam logic [F_W:0]          F_POS_LIM = 35'h1_FFFF_FFFF;
  localparam logic [F_W:0]          F_NEG_LIM = 35'h2_0000_0000;
  localparam logic signed [F_W-1:0] F_MAX     = 34'sh1_FFFF_FFFF;
  localparam logic signed [F_W-1:0] F_MIN     = 34'sh2_0000_0000;

  localparam logic [U_QW:0]         S_POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [U_QW:0]         S_NEG_LIM = 33'h0_8000_0000;
  localparam logic signed [31:0]    S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]    S32_MIN   = 32'sh8000_0000;

  localparam logic signed [F_W:0]   H_HI      = 35'sh0_7FFF_FFFF;
  localparam logic signed [F_W:0]   H_LO      = 35'sh7_8000_0000;

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2
  } corner_t;

  typedef struct packed {
    corner_t corner;
    logic    last;
    logic    singular;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic neg;
  } ftag_t;

  typedef struct packed {
    tag_t             tag;
    logic [3:0][31:0] grad;
    logic [CM_W-1:0]  n0;
    logic [CM_W-1:0]  n1;
    logic [CM_W-1:0]  n3;
    logic             n1neg;
  } sqsb_t;

  typedef struct packed {
    tag_t             tag;
    logic [3:0][31:0] grad;
  } utag_t;

  function automatic logic signed [F_W-1:0] f_clamp(input logic [F_W:0] qr, input logic ovf,
                                                    input logic neg);
    logic signed [F_W+1:0] nv;
    nv = -$signed({1'b0, qr});
    if (neg) begin
      if (ovf || qr > F_NEG_LIM) return F_MIN;
      return nv[F_W-1:0];
    end
    if (ovf || qr > F_POS_LIM) return F_MAX;
    return $signed(qr[F_W-1:0]);
  endfunction

  function automatic logic signed [31:0] s_clamp(input logic [U_QW:0] qr, input logic ovf,
                                                 input logic neg);
    logic signed [U_QW+1:0] nv;
    nv = -$signed({1'b0, qr});
    if (neg) begin
      if (ovf || qr > S_NEG_LIM) return S32_MIN;
      return nv[31:0];
    end
    if (ovf || qr > S_POS_LIM) return S32_MAX;
    return $signed(qr[31:0]);
  endfunction

  function automatic logic signed [31:0] h_sat(input logic signed [F_W:0] x);
    if (x > H_HI) return S32_MAX;
    if (x < H_LO) return S32_MIN;
    return x[31:0];
  endfunction

endpackage

[hw/rtl/tcs_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, rounded to nearest
module tcs_div #(
  parameter int NW = 67,
  parameter int SH = 16,
  parameter int DW = 67,
  parameter int QW = 34,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output logic [QW:0]   quo,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  localparam int XW = NW + SH;
  localparam int CW = ((XW > DW + QW) ? XW : DW + QW) + 1;

  logic [CW-1:0] rm_r [QW+1];
  logic [QW-1:0] q_r  [QW+1];
  logic [DW-1:0] d_r  [QW+1];
  logic          ov_r [QW+1];
  logic [TW-1:0] tg_r [QW+1];
  logic          v_r  [QW+1];

  logic [CW-1:0] num_x;
  logic [CW-1:0] den_top;
  logic          rnd;
  logic          vo_r;
  logic [QW:0]   quo_r;
  logic          ovo_r;
  logic [TW-1:0] tgo_r;

  assign num_x   = CW'(num) << SH;
  assign den_top = CW'(den) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0] <= num_x;
      q_r[0]  <= '0;
      d_r[0]  <= den;
      ov_r[0] <= (num_x >= den_top);
      tg_r[0] <= tag_in;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [CW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_nxt;

    always_comb begin
      trial         = CW'(d_r[i-1]) << (QW - i);
      ge            = (rm_r[i-1] >= trial);
      q_nxt         = q_r[i-1];
      q_nxt[QW - i] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[i] <= ge ? rm_r[i-1] - trial : rm_r[i-1];
        q_r[i]  <= q_nxt;
        d_r[i]  <= d_r[i-1];
        ov_r[i] <= ov_r[i-1];
        tg_r[i] <= tg_r[i-1];
      end
    end
  end

  assign rnd = ((rm_r[QW] << 1) >= CW'(d_r[QW]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= (QW+1)'(q_r[QW]) + (QW+1)'(rnd);
      ovo_r <= ov_r[QW];
      tgo_r <= tg_r[QW];
    end
  end

  assign vld_out = vo_r;
  assign quo     = quo_r;
  assign ovf     = ovo_r;
  assign tag_out = tgo_r;

endmodule

[hw/rtl/triangle_corner_strain_core.sv]
`timescale 1ns / 1ps
// top level: per-corner displacement gradient and right stretch tensor of a triangle
//
// One input word is a triangle: xy of three reference and three deformed vertices,
// signed fixed point with FRAC_BITS fraction bits. Each accepted triangle yields three
// output words in corner order (corner 0, 1, 2, last set on corner 2), each holding
// H = F - I and U = sqrt(F^T F) for that corner, saturated to 32 bits. A corner whose
// reference edges are collinear reports singular with all matrix fields zero.
// Both channels use valid/stall; a word moves when valid is high and stall is low.
// Throughput: one corner per cycle while the output is not stalled; in_stall is high
// while the held triangle still has corners to issue. From acceptance, each corner runs
// through the 34-stage F divider, the FRAC_BITS + 35 stage square root and the
// 32-stage U divider. A stall on the output while a word is held there freezes the
// whole pipeline in place; nothing is lost or repeated. Synchronous reset empties the
// pipeline; no words are in flight after it.
module triangle_corner_strain_core
  import tcs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ref_ax,
  input  logic signed [31:0] in_ref_ay,
  input  logic signed [31:0] in_ref_bx,
  input  logic signed [31:0] in_ref_by,
  input  logic signed [31:0] in_ref_cx,
  input  logic signed [31:0] in_ref_cy,
  input  logic signed [31:0] in_def_ax,
  input  logic signed [31:0] in_def_ay,
  input  logic signed [31:0] in_def_bx,
  input  logic signed [31:0] in_def_by,
  input  logic signed [31:0] in_def_cx,
  input  logic signed [31:0] in_def_cy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_corner,
  output logic               out_last,
  output logic               out_singular,
  output logic signed [31:0] out_grad_00,
  output logic signed [31:0] out_grad_01,
  output logic signed [31:0] out_grad_10,
  output logic signed [31:0] out_grad_11,
  output logic signed [31:0] out_stretch_00,
  output logic signed [31:0] out_stretch_01,
  output logic signed [31:0] out_stretch_10,
  output logic signed [31:0] out_stretch_11
);

  localparam int RAD_W = CM_W + 2 * FRAC_BITS;
  localparam int RT_W  = RAD_W / 2;
  localparam logic signed [F_W:0] ONE_Q = 35'sd1 <<< FRAC_BITS;

  logic adv;
  logic in_take;
  logic issue;

  // triangle holding register and corner sequencer
  logic signed [CRD_W-1:0] rx_r [3];
  logic signed [CRD_W-1:0] ry_r [3];
  logic signed [CRD_W-1:0] tx_r [3];
  logic signed [CRD_W-1:0] ty_r [3];
  logic    tv_r, tv_nxt;
  corner_t cnt_r, cnt_nxt;
  logic [1:0] ik, iu, iv;

  logic ov_r;
  assign adv      = !ov_r || !out_stall;
  assign issue    = tv_r && adv;
  assign in_stall = tv_r && !(issue && cnt_r == CORNER_C);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    tv_nxt  = tv_r;
    cnt_nxt = cnt_r;
    if (issue) begin
      case (cnt_r)
        CORNER_A: cnt_nxt = CORNER_B;
        CORNER_B: cnt_nxt = CORNER_C;
        default: begin
          cnt_nxt = CORNER_A;
          tv_nxt  = 1'b0;
        end
      endcase
    end
    if (in_take) begin
      tv_nxt  = 1'b1;
      cnt_nxt = CORNER_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r  <= 1'b0;
      cnt_r <= CORNER_A;
    end else begin
      tv_r  <= tv_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rx_r[0] <= in_ref_ax;  ry_r[0] <= in_ref_ay;
      rx_r[1] <= in_ref_bx;  ry_r[1] <= in_ref_by;
      rx_r[2] <= in_ref_cx;  ry_r[2] <= in_ref_cy;
      tx_r[0] <= in_def_ax;  ty_r[0] <= in_def_ay;
      tx_r[1] <= in_def_bx;  ty_r[1] <= in_def_by;
      tx_r[2] <= in_def_cx;  ty_r[2] <= in_def_cy;
    end
  end

  always_comb begin
    case (cnt_r)
      CORNER_A: begin ik = 2'd0; iu = 2'd1; iv = 2'd2; end
      CORNER_B: begin ik = 2'd1; iu = 2'd0; iv = 2'd2; end
      CORNER_C: begin ik = 2'd2; iu = 2'd0; iv = 2'd1; end
      default:  begin ik = 2'd0; iu = 2'd1; iv = 2'd2; end
    endcase
  end

  // stage a: edge vectors
  logic signed [EDGE_W-1:0] ea_nxt, eb_nxt, ec_nxt, ed_nxt, ep_nxt, eq_nxt, er_nxt, es_nxt;
  logic signed [EDGE_W-1:0] ea_r, eb_r, ec_r, ed_r, ep_r, eq_r, er_r, es_r;
  tag_t ta_r;
  logic va_r;

  always_comb begin
    ea_nxt = EDGE_W'(rx_r[ik]) - EDGE_W'(rx_r[iu]);
    ec_nxt = EDGE_W'(ry_r[ik]) - EDGE_W'(ry_r[iu]);
    eb_nxt = EDGE_W'(rx_r[ik]) - EDGE_W'(rx_r[iv]);
    ed_nxt = EDGE_W'(ry_r[ik]) - EDGE_W'(ry_r[iv]);
    ep_nxt = EDGE_W'(tx_r[ik]) - EDGE_W'(tx_r[iu]);
    er_nxt = EDGE_W'(ty_r[ik]) - EDGE_W'(ty_r[iu]);
    eq_nxt = EDGE_W'(tx_r[ik]) - EDGE_W'(tx_r[iv]);
    es_nxt = EDGE_W'(ty_r[ik]) - EDGE_W'(ty_r[iv]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= tv_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ea_r <= ea_nxt; eb_r <= eb_nxt; ec_r <= ec_nxt; ed_r <= ed_nxt;
      ep_r <= ep_nxt; eq_r <= eq_nxt; er_r <= er_nxt; es_r <= es_nxt;
      ta_r.corner   <= cnt_r;
      ta_r.last     <= (cnt_r == CORNER_C);
      ta_r.singular <= 1'b0;
    end
  end

  // stage b: cross products
  logic signed [PROD_W-1:0] pl_r [4];
  logic signed [PROD_W-1:0] pr_r [4];
  logic signed [PROD_W-1:0] pdl_r, pdr_r;
  tag_t tb_r;
  logic vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pdl_r   <= ea_r * ed_r;  pdr_r   <= eb_r * ec_r;
      pl_r[0] <= ep_r * ed_r;  pr_r[0] <= eq_r * ec_r;
      pl_r[1] <= eq_r * ea_r;  pr_r[1] <= ep_r * eb_r;
      pl_r[2] <= er_r * ed_r;  pr_r[2] <= es_r * ec_r;
      pl_r[3] <= es_r * ea_r;  pr_r[3] <= er_r * eb_r;
      tb_r    <= ta_r;
    end
  end

  // stage c: determinant and adjugate numerators
  logic signed [DET_W-1:0] det_r;
  logic signed [DET_W-1:0] nm_r [4];
  tag_t tc_r;
  logic vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= DET_W'(pdl_r) - DET_W'(pdr_r);
      for (int g = 0; g < 4; g++) nm_r[g] <= DET_W'(pl_r[g]) - DET_W'(pr_r[g]);
      tc_r <= tb_r;
    end
  end

  // stage d: magnitudes and signs for the divider
  logic [DET_W-1:0] dmag_r;
  logic [DET_W-1:0] nmag_r [4];
  logic             nneg_r [4];
  tag_t td_r;
  logic vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (adv) vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r <= det_r[DET_W-1] ? $unsigned(-det_r) : $unsigned(det_r);
      for (int g = 0; g < 4; g++) begin
        nmag_r[g] <= nm_r[g][DET_W-1] ? $unsigned(-nm_r[g]) : $unsigned(nm_r[g]);
        nneg_r[g] <= nm_r[g][DET_W-1] ^ det_r[DET_W-1];
      end
      td_r.corner   <= tc_r.corner;
      td_r.last     <= tc_r.last;
      td_r.singular <= (det_r == '0);
    end
  end

  // F = adj * (1 / det), four dividers in parallel
  logic [F_W:0] fq [4];
  logic         fov [4];
  ftag_t        ftg_in, ftg_out;
  logic         fneg [4];
  logic         fv;

  assign ftg_in  = '{tag: td_r, neg: nneg_r[0]};
  assign fneg[0] = ftg_out.neg;

  tcs_div #(
    .NW(DET_W), .SH(FRAC_BITS), .DW(DET_W), .QW(F_W), .TW($bits(ftag_t))
  ) u_fdiv0 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(vd_r),
    .num(nmag_r[0]), .den(dmag_r), .tag_in(ftg_in),
    .vld_out(fv), .quo(fq[0]), .ovf(fov[0]), .tag_out(ftg_out)
  );

  for (genvar g = 1; g < 4; g++) begin : g_fdiv
    tcs_div #(
      .NW(DET_W), .SH(FRAC_BITS), .DW(DET_W), .QW(F_W), .TW(1)
    ) u_fdiv (
      .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(vd_r),
      .num(nmag_r[g]), .den(dmag_r), .tag_in(nneg_r[g]),
      .vld_out(), .quo(fq[g]), .ovf(fov[g]), .tag_out(fneg[g])
    );
  end

  // stage e: clamp F
  logic signed [F_W-1:0] f_r [4];
  tag_t te_r;
  logic ve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (adv) ve_r <= fv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 4; g++) f_r[g] <= f_clamp(fq[g], fov[g], fneg[g]);
      te_r <= ftg_out.tag;
    end
  end

  // stage f: products of F and displacement gradient
  logic signed [FPROD_W-1:0] c0a_r, c0b_r, c1a_r, c1b_r, c3a_r, c3b_r, sda_r, sdb_r;
  logic signed [31:0] grad_r [4];
  tag_t tf_r;
  logic vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (adv) vf_r <= ve_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0a_r <= f_r[0] * f_r[0];  c0b_r <= f_r[2] * f_r[2];
      c1a_r <= f_r[0] * f_r[1];  c1b_r <= f_r[2] * f_r[3];
      c3a_r <= f_r[1] * f_r[1];  c3b_r <= f_r[3] * f_r[3];
      sda_r <= f_r[0] * f_r[3];  sdb_r <= f_r[1] * f_r[2];
      for (int g = 0; g < 4; g++) begin
        grad_r[g] <= te_r.singular ? 32'sd0 :
                     h_sat((F_W+1)'(f_r[g]) - (((g == 0) || (g == 3)) ? ONE_Q : '0));
      end
      tf_r <= te_r;
    end
  end

  // stage g: C = F^T F and det F
  logic signed [CM_W-1:0] cm0_r, cm1_r, cm3_r, sd_r;
  logic signed [31:0] grad_g_r [4];
  tag_t tg_r;
  logic vg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vg_r <= 1'b0;
    else if (adv) vg_r <= vf_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm0_r <= CM_W'(c0a_r) + CM_W'(c0b_r);
      cm1_r <= CM_W'(c1a_r) + CM_W'(c1b_r);
      cm3_r <= CM_W'(c3a_r) + CM_W'(c3b_r);
      sd_r  <= CM_W'(sda_r) - CM_W'(sdb_r);
      grad_g_r <= grad_r;
      tg_r  <= tf_r;
    end
  end

  // stage h: |det F|
  logic [CM_W-1:0] cm0_h_r, cm3_h_r, sabs_r;
  logic signed [CM_W-1:0] cm1_h_r;
  logic signed [31:0] grad_h_r [4];
  tag_t th_r;
  logic vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vh_r <= 1'b0;
    else if (adv) vh_r <= vg_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm0_h_r  <= $unsigned(cm0_r);
      cm3_h_r  <= $unsigned(cm3_r);
      cm1_h_r  <= cm1_r;
      sabs_r   <= sd_r[CM_W-1] ? $unsigned(-sd_r) : $unsigned(sd_r);
      grad_h_r <= grad_g_r;
      th_r     <= tg_r;
    end
  end

  // stage i and square root pipeline, one root bit per stage
  logic [RAD_W-1:0] rm_r [RT_W+1];
  logic [RT_W-1:0]  rt_r [RT_W+1];
  sqsb_t            sb_r [RT_W+1];
  logic             sv_r [RT_W+1];
  logic [CM_W-1:0]  tr2_nxt;
  sqsb_t            sb_nxt;

  always_comb begin
    tr2_nxt = cm0_h_r + cm3_h_r + (sabs_r << 1);
    sb_nxt.tag   = th_r;
    for (int g = 0; g < 4; g++) sb_nxt.grad[g] = grad_h_r[g];
    sb_nxt.n0    = cm0_h_r + sabs_r;
    sb_nxt.n3    = cm3_h_r + sabs_r;
    sb_nxt.n1neg = cm1_h_r[CM_W-1];
    sb_nxt.n1    = cm1_h_r[CM_W-1] ? $unsigned(-cm1_h_r) : $unsigned(cm1_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (adv) sv_r[0] <= vh_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rm_r[0] <= {tr2_nxt, {(2 * FRAC_BITS){1'b0}}};
      rt_r[0] <= '0;
      sb_r[0] <= sb_nxt;
    end
  end

  for (genvar j = 1; j <= RT_W; j++) begin : g_sqrt
    localparam int BI = RT_W - j;
    logic [RAD_W:0]  trial;
    logic            ge;
    logic [RT_W-1:0] rt_nxt;

    always_comb begin
      trial      = ((RAD_W+1)'(rt_r[j-1]) << (BI + 1)) | ((RAD_W+1)'(1) << (2 * BI));
      ge         = ((RAD_W+1)'(rm_r[j-1]) >= trial);
      rt_nxt     = rt_r[j-1];
      rt_nxt[BI] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j] <= 1'b0;
      else if (adv) sv_r[j] <= sv_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rm_r[j] <= ge ? rm_r[j-1] - trial[RAD_W-1:0] : rm_r[j-1];
        rt_r[j] <= rt_nxt;
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // U = (C + s I) / t
  utag_t          ut_in, ut_out;
  logic [U_QW:0]  uq0, uq1, uq3;
  logic           uov0, uov1, uov3;
  logic           un1neg, utzero, tzero;
  logic           uv;

  assign ut_in = '{tag: sb_r[RT_W].tag, grad: sb_r[RT_W].grad};
  assign tzero = (rt_r[RT_W] == '0);

  tcs_div #(
    .NW(CM_W), .SH(FRAC_BITS), .DW(RT_W), .QW(U_QW), .TW($bits(utag_t))
  ) u_udiv0 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(sv_r[RT_W]),
    .num(sb_r[RT_W].n0), .den(rt_r[RT_W]), .tag_in(ut_in),
    .vld_out(uv), .quo(uq0), .ovf(uov0), .tag_out(ut_out)
  );

  tcs_div #(
    .NW(CM_W), .SH(FRAC_BITS), .DW(RT_W), .QW(U_QW), .TW(1)
  ) u_udiv1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(sv_r[RT_W]),
    .num(sb_r[RT_W].n1), .den(rt_r[RT_W]), .tag_in(sb_r[RT_W].n1neg),
    .vld_out(), .quo(uq1), .ovf(uov1), .tag_out(un1neg)
  );

  tcs_div #(
    .NW(CM_W), .SH(FRAC_BITS), .DW(RT_W), .QW(U_QW), .TW(1)
  ) u_udiv3 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(sv_r[RT_W]),
    .num(sb_r[RT_W].n3), .den(rt_r[RT_W]), .tag_in(tzero),
    .vld_out(), .quo(uq3), .ovf(uov3), .tag_out(utzero)
  );

  // output register
  tag_t               ot_r;
  logic signed [31:0] og_r [4];
  logic signed [31:0] os_r [4];
  logic               zs;

  assign zs = utzero || ut_out.tag.singular;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= uv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ot_r <= ut_out.tag;
      for (int g = 0; g < 4; g++) og_r[g] <= ut_out.grad[g];
      os_r[0] <= zs ? 32'sd0 : s_clamp(uq0, uov0, 1'b0);
      os_r[1] <= zs ? 32'sd0 : s_clamp(uq1, uov1, un1neg);
      os_r[2] <= zs ? 32'sd0 : s_clamp(uq1, uov1, un1neg);
      os_r[3] <= zs ? 32'sd0 : s_clamp(uq3, uov3, 1'b0);
    end
  end

  assign out_valid      = ov_r;
  assign out_corner     = ot_r.corner;
  assign out_last       = ot_r.last;
  assign out_singular   = ot_r.singular;
  assign out_grad_00    = og_r[0];
  assign out_grad_01    = og_r[1];
  assign out_grad_10    = og_r[2];
  assign out_grad_11    = og_r[3];
  assign out_stretch_00 = os_r[0];
  assign out_stretch_01 = os_r[1];
  assign out_stretch_10 = os_r[2];
  assign out_stretch_11 = os_r[3];

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_corner == CORNER_C)
    else $error("last flag on a corner other than the third");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_grad_00 == 0 && out_grad_11 == 0 &&
      out_stretch_00 == 0 && out_stretch_01 == 0 && out_stretch_11 == 0)
    else $error("singular corner with nonzero matrix fields");

  a_take_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !tv_r || (cnt_r == CORNER_C && adv))
    else $error("triangle taken while corners still pending");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    issue && cnt_r == CORNER_A |=> tv_r && cnt_r == CORNER_B)
    else $error("corner sequencer skipped a corner");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the triangle corner strain core: directed table, random triangles
module tb_top;

  localparam int FB = 16;
  localparam int LAT = FB + 115;
  localparam int N_RAND = 400;

  typedef struct {
    logic [1:0]  corner;
    logic        last;
    logic        singular;
    logic [31:0] grad [4];
    logic [31:0] stretch [4];
  } strain_t;

  typedef struct {
    logic signed [31:0] v [12];
    bit                 has_exp;
    logic [31:0]        exp_grad0;
    logic               exp_sing;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] crd [12];
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_corner;
  logic out_last, out_singular;
  logic signed [31:0] g00, g01, g10, g11, s00, s01, s10, s11;

  strain_t expected_q[$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  bit drain_wait = 1'b0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < 12; i++) crd[i] = '0;
  end

  triangle_corner_strain_core #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_ref_ax(crd[0]), .in_ref_ay(crd[1]), .in_ref_bx(crd[2]), .in_ref_by(crd[3]),
    .in_ref_cx(crd[4]), .in_ref_cy(crd[5]), .in_def_ax(crd[6]), .in_def_ay(crd[7]),
    .in_def_bx(crd[8]), .in_def_by(crd[9]), .in_def_cx(crd[10]), .in_def_cy(crd[11]),
    .out_valid(out_valid), .out_stall(out_stall), .out_corner(out_corner),
    .out_last(out_last), .out_singular(out_singular),
    .out_grad_00(g00), .out_grad_01(g01), .out_grad_10(g10), .out_grad_11(g11),
    .out_stretch_00(s00), .out_stretch_01(s01), .out_stretch_10(s10), .out_stretch_11(s11)
  );

  // signed divide, nearest with ties away from zero
  function automatic logic signed [159:0] div_round(input logic signed [159:0] n,
                                                    input logic signed [159:0] d);
    logic [159:0] un, ud, q, r;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = un / ud;
    r = un % ud;
    if ((r << 1) >= ud) q = q + 1;
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [159:0] clamp(input logic signed [159:0] x,
                                                input logic signed [159:0] lo,
                                                input logic signed [159:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [31:0] lo32(input logic signed [159:0] x);
    return x[31:0];
  endfunction

  function automatic logic [159:0] isqrt(input logic [159:0] n);
    logic [159:0] res, bit_v;
    res = '0;
    bit_v = 160'd1 << 158;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  task automatic predict_corners(input logic signed [31:0] v [12]);
    logic signed [159:0] rx [3], ry [3], tx [3], ty [3];
    logic signed [159:0] a, b, c, d, p, q, r, s, det, nm [4], f [4], cm [4], sd, t;
    logic signed [159:0] one, fmax, fmin, smax, smin;
    int u, w;
    strain_t e;
    one = 160'sd1 <<< FB;
    fmax = (160'sd1 <<< 33) - 1;
    fmin = -(160'sd1 <<< 33);
    smax = 160'sd2147483647;
    smin = -160'sd2147483648;
    for (int i = 0; i < 3; i++) begin
      rx[i] = v[2*i]; ry[i] = v[2*i+1]; tx[i] = v[6+2*i]; ty[i] = v[7+2*i];
    end
    for (int k = 0; k < 3; k++) begin
      u = (k == 0) ? 1 : 0;
      w = (k == 2) ? 1 : 2;
      a = rx[k] - rx[u]; c = ry[k] - ry[u]; b = rx[k] - rx[w]; d = ry[k] - ry[w];
      p = tx[k] - tx[u]; r = ty[k] - ty[u]; q = tx[k] - tx[w]; s = ty[k] - ty[w];
      det = a * d - b * c;
      e.corner = k[1:0];
      e.last = (k == 2);
      e.singular = (det == 0);
      for (int i = 0; i < 4; i++) begin
        e.grad[i] = '0;
        e.stretch[i] = '0;
      end
      if (det != 0) begin
        nm[0] = p * d - q * c; nm[1] = q * a - p * b;
        nm[2] = r * d - s * c; nm[3] = s * a - r * b;
        for (int i = 0; i < 4; i++) begin
          f[i] = clamp(div_round(nm[i] <<< FB, det), fmin, fmax);
          e.grad[i] = lo32(clamp(f[i] - ((i == 0 || i == 3) ? one : 0), smin, smax));
        end
        cm[0] = f[0] * f[0] + f[2] * f[2];
        cm[1] = f[0] * f[1] + f[2] * f[3];
        cm[2] = cm[1];
        cm[3] = f[1] * f[1] + f[3] * f[3];
        sd = f[0] * f[3] - f[1] * f[2];
        if (sd < 0) sd = -sd;
        t = isqrt((cm[0] + cm[3] + 2 * sd) <<< (2 * FB));
        if (t != 0) begin
          cm[0] = cm[0] + sd;
          cm[3] = cm[3] + sd;
          for (int i = 0; i < 4; i++)
            e.stretch[i] = lo32(clamp(div_round(cm[i] <<< FB, t), smin, smax));
        end
      end
      expected_q.push_back(e);
    end
  endtask

  function automatic logic signed [31:0] rand_crd(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      2: return $signed($urandom_range(0, 32'h3FF)) - 32'sh200;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic send_triangle(input logic signed [31:0] v [12]);
    for (int i = 0; i < 12; i++) crd[i] <= v[i];
    in_valid <= 1'b1;
    predict_corners(v);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // directed rows
  stim_row_t dir_tab [$];

  task automatic add_row(input logic signed [31:0] v [12], input bit he,
                         input logic [31:0] g0, input logic sg);
    stim_row_t row;
    row.v = v; row.has_exp = he; row.exp_grad0 = g0; row.exp_sing = sg;
    dir_tab.push_back(row);
  endtask

  initial begin
    logic signed [31:0] v [12];
    int mode;
    // identity: unit right triangle, same deformed
    v = '{0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'sh10000};
    add_row(v, 1'b1, 32'h0, 1'b0);
    // all reference points coincide: singular
    v = '{5, 5, 5, 5, 5, 5, 1, 2, 3, 4, 5, 6};
    add_row(v, 1'b1, 32'h0, 1'b1);
    // collinear reference: singular
    v = '{0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 0, 0, 7, 8, 9, 1};
    add_row(v, 1'b1, 32'h0, 1'b1);
    // deformed collapsed to a point: zero F
    v = '{0, 0, 32'sh10000, 0, 0, 32'sh10000, 3, 3, 3, 3, 3, 3};
    add_row(v, 1'b1, 32'hFFFF_0000, 1'b0);
    // tiny reference, huge deformation: F clamp
    v = '{0, 0, 1, 0, 0, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    add_row(v, 1'b0, 32'h0, 1'b0);
    v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
    add_row(v, 1'b0, 32'h0, 1'b0);
    v = '{0, 0, 1, 0, 0, 1, 0, 0, -1, 0, 0, 1};
    add_row(v, 1'b0, 32'h0, 1'b0);
    v = '{0, 0, 32'sh20000, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh30000};
    add_row(v, 1'b0, 32'h0, 1'b0);
    for (int j = 0; j < 8; j++) begin
      for (int i = 0; i < 12; i++) v[i] = rand_crd(j % 4);
      add_row(v, 1'b0, 32'h0, 1'b0);
    end
    for (int i = 0; i < 12; i++) v[i] = -1;
    add_row(v, 1'b1, 32'h0, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[j]) begin
      send_triangle(dir_tab[j].v);
      if (dir_tab[j].has_exp) begin
        for (int k = 1; k <= 3; k++) begin
          if (expected_q[expected_q.size()-k].grad[0] !== dir_tab[j].exp_grad0 ||
              expected_q[expected_q.size()-k].singular !== dir_tab[j].exp_sing) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table row %0d corner %0d: expected grad0 %h sing %b got %h %b",
                       j, 3 - k, dir_tab[j].exp_grad0, dir_tab[j].exp_sing,
                       expected_q[expected_q.size()-k].grad[0],
                       expected_q[expected_q.size()-k].singular);
          end
        end
      end
      idle_gap();
    end

    for (int n = 0; n < N_RAND; n++) begin
      if (n == 100) hold_off = 1'b1;
      if (n == 250) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
      end
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++)
        v[i] = rand_crd(mode < 2 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : 3);
      if ($urandom_range(0, 15) == 0) begin
        v[4] = v[0] + (v[2] - v[0]) * 2;
        v[5] = v[1] + (v[3] - v[1]) * 2;
      end
      send_triangle(v);
      idle_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side stall
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
      end
    end
  end

  // checker
  always @(posedge clk) begin
    strain_t e;
    logic [31:0] got_g [4], got_s [4];
    bit bad;
    if (rst_n && out_valid && !out_stall) begin
      got_g = '{g00, g01, g10, g11};
      got_s = '{s00, s01, s10, s11};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected corner word %0d", out_corner);
      end else begin
        e = expected_q.pop_front();
        bad = (out_corner !== e.corner) || (out_last !== e.last) ||
              (out_singular !== e.singular);
        for (int i = 0; i < 4; i++)
          if (got_g[i] !== e.grad[i] || got_s[i] !== e.stretch[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("corner exp %0d/%b/%b got %0d/%b/%b", e.corner, e.last, e.singular,
                     out_corner, out_last, out_singular);
            $display("  grad exp %h %h %h %h got %h %h %h %h", e.grad[0], e.grad[1],
                     e.grad[2], e.grad[3], got_g[0], got_g[1], got_g[2], got_g[3]);
            $display("  stretch exp %h %h %h %h got %h %h %h %h", e.stretch[0],
                     e.stretch[1], e.stretch[2], e.stretch[3], got_s[0], got_s[1],
                     got_s[2], got_s[3]);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_div.sv
hw/rtl/triangle_corner_strain_core.sv
sim/tb_top.sv
